>>> rtl/brke_pkg.sv
// ----------------------------------------------------------------------------
// brke_pkg
// Types and constants shared by the battery runtime estimator modules.
// ----------------------------------------------------------------------------
package brke_pkg;

   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_MEASURE = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;
   localparam logic [1:0] OP_SPARE   = 2'd3;

   localparam logic [2:0] CSR_FULL_VOLTAGE      = 3'd0;
   localparam logic [2:0] CSR_EMPTY_VOLTAGE     = 3'd1;
   localparam logic [2:0] CSR_DEFAULT_RUNTIME   = 3'd2;
   localparam logic [2:0] CSR_PROCESS_NOISE     = 3'd3;
   localparam logic [2:0] CSR_MEASUREMENT_NOISE = 3'd4;

   localparam logic [28:0] CAP_MIN_MS = 29'd100;
   localparam logic [28:0] CAP_MAX_MS = 29'd360000000;
   localparam logic [39:0] ELAPSED_MAX = 40'hFF_FFFF_FFFF;

   localparam int DVD_W = 64;
   localparam int DVS_W = 33;
   localparam int SQ_W  = 48;
   localparam int RT_W  = 24;

   typedef struct packed {
      logic [1:0]  op;
      logic [23:0] time_step;
      logic [15:0] voltage_sample;
   } req_type;

   typedef struct packed {
      logic [28:0] remaining_time;
      logic [31:0] variance;
      logic [15:0] uncertainty;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

>>> rtl/brke_div.sv
// ----------------------------------------------------------------------------
// brke_div
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module brke_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [brke_pkg::DVD_W-1:0]    dividend,
   input  logic [brke_pkg::DVS_W-1:0]    divisor,
   output logic [brke_pkg::DVD_W-1:0]    quotient,
   output brke_pkg::unit_status_type     status
);

   logic [brke_pkg::DVD_W-1:0] dvd_ff, dvd_in;
   logic [brke_pkg::DVS_W:0]   rem_ff, rem_in;
   logic [brke_pkg::DVS_W-1:0] dvs_ff, dvs_in;
   logic [5:0]                 cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [brke_pkg::DVS_W:0]   rem_sh;

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[brke_pkg::DVS_W-1:0], dvd_ff[brke_pkg::DVD_W-1]};
      if (start) begin
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
         cnt_in  = '1;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = rem_sh - {1'b0, dvs_ff};
            dvd_in = {dvd_ff[brke_pkg::DVD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            dvd_in = {dvd_ff[brke_pkg::DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient    = dvd_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

>>> rtl/brke_isqrt.sv
// ----------------------------------------------------------------------------
// brke_isqrt
// Integer square root, two operand bits per cycle.
// ----------------------------------------------------------------------------
module brke_isqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [brke_pkg::SQ_W-1:0]   operand,
   output logic [brke_pkg::RT_W-1:0]   root,
   output brke_pkg::unit_status_type   status
);

   logic [brke_pkg::SQ_W-1:0] opnd_ff, opnd_in;
   logic [brke_pkg::RT_W+2:0] rem_ff, rem_in;
   logic [brke_pkg::RT_W-1:0] root_ff, root_in;
   logic [4:0]                cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [brke_pkg::RT_W+2:0] rem_sh;
   logic [brke_pkg::RT_W+2:0] trial;

   always_comb begin
      opnd_in = opnd_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[brke_pkg::RT_W:0], opnd_ff[brke_pkg::SQ_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      if (start) begin
         opnd_in = operand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = 5'(brke_pkg::RT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         opnd_in = {opnd_ff[brke_pkg::SQ_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[brke_pkg::RT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[brke_pkg::RT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      opnd_ff <= opnd_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign root        = root_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

>>> rtl/battery_runtime_kalman_estimator.sv
// ----------------------------------------------------------------------------
// battery_runtime_kalman_estimator
// Scalar Kalman estimator of remaining battery runtime, run by a sequencer
// over one shared multiplier, a bit-serial divider and a square root unit.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  req      in         req_valid/stall    op, time_step, voltage_sample
//  rsp      out        rsp_valid/stall    remaining_time, variance, uncertainty
//  csr      in         csr_write          csr_index, csr_wdata
//
// A tick, restart or unused code runs no division, only the square root.
// A measurement runs up to four divisions before the square root.
// Reset is synchronous and restores the configuration registers and the filter state.
// A new beat is taken only when idle and no result beat is waiting.
// ----------------------------------------------------------------------------
module battery_runtime_kalman_estimator #(
   parameter int FRACTION_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  brke_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output brke_pkg::rsp_type  rsp_data,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [28:0]        csr_wdata
);

   localparam logic [31:0] COV_ONE = 32'd1 << FRACTION_BITS;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CAP   = 4'd1;
   localparam logic [3:0] S_CAPQ  = 4'd2;
   localparam logic [3:0] S_Z     = 4'd3;
   localparam logic [3:0] S_ZQ    = 4'd4;
   localparam logic [3:0] S_K     = 4'd5;
   localparam logic [3:0] S_KQ    = 4'd6;
   localparam logic [3:0] S_PQ    = 4'd7;
   localparam logic [3:0] S_CLAMP = 4'd8;
   localparam logic [3:0] S_MUL   = 4'd9;
   localparam logic [3:0] S_DIVS  = 4'd10;
   localparam logic [3:0] S_DIVW  = 4'd11;
   localparam logic [3:0] S_SQS   = 4'd12;
   localparam logic [3:0] S_SQW   = 4'd13;

   logic [15:0] full_ff, empty_ff, q_ff, r_ff;
   logic [28:0] dflt_ff;

   logic [3:0]  state_ff, state_in;
   logic [3:0]  ret_ff, ret_in;
   logic [1:0]  op_ff, op_in;
   logic [23:0] dt_ff, dt_in;
   logic [15:0] v_ff, v_in;
   logic [28:0] est_ff, est_in;
   logic [31:0] cov_ff, cov_in;
   logic [39:0] el_ff, el_in;
   logic [15:0] startv_ff, startv_in;
   logic        first_ff, first_in;
   logic [28:0] cap_ff, cap_in;
   logic [28:0] z_ff, z_in;
   logic [39:0] mula_ff, mula_in;
   logic [31:0] mulb_ff, mulb_in;
   logic [63:0] prod_ff, prod_in;
   logic [32:0] dvs_ff, dvs_in;
   logic [15:0] unc_ff, unc_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic                      div_start, sq_start;
   logic [63:0]               quotient;
   logic [brke_pkg::RT_W-1:0] root;
   brke_pkg::unit_status_type div_status, sq_status;
   logic [brke_pkg::SQ_W-1:0] sq_operand;

   logic        accept;
   logic [15:0] dfe, sv_eff;
   logic [39:0] el_eff;
   logic [40:0] el_sum;
   logic [32:0] cov_sum, denom;
   logic [28:0] mag;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign dfe       = full_ff - empty_ff;
   assign sv_eff    = first_ff ? v_ff : startv_ff;
   assign el_eff    = first_ff ? 40'd1 : el_ff;
   assign el_sum    = {1'b0, el_ff} + {17'd0, dt_ff};
   assign cov_sum   = {1'b0, cov_ff} + {17'd0, q_ff};
   assign denom     = {1'b0, cov_ff} + {17'd0, r_ff};
   assign mag       = (z_ff >= est_ff) ? (z_ff - est_ff) : (est_ff - z_ff);

   always_comb begin
      if (FRACTION_BITS <= 16) begin
         sq_operand = {16'd0, cov_ff} << (16 - FRACTION_BITS);
      end else begin
         sq_operand = {16'd0, cov_ff} >> (FRACTION_BITS - 16);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff  <= 16'd12700;
         empty_ff <= 16'd10500;
         dflt_ff  <= 29'd3600000;
         q_ff     <= 16'd66;
         r_ff     <= 16'd3277;
      end else if (csr_write) begin
         case (csr_index)
            brke_pkg::CSR_FULL_VOLTAGE:      full_ff  <= csr_wdata[15:0];
            brke_pkg::CSR_EMPTY_VOLTAGE:     empty_ff <= csr_wdata[15:0];
            brke_pkg::CSR_DEFAULT_RUNTIME:   dflt_ff  <= csr_wdata;
            brke_pkg::CSR_PROCESS_NOISE:     q_ff     <= csr_wdata[15:0];
            brke_pkg::CSR_MEASUREMENT_NOISE: r_ff     <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      op_in        = op_ff;
      dt_in        = dt_ff;
      v_in         = v_ff;
      est_in       = est_ff;
      cov_in       = cov_ff;
      el_in        = el_ff;
      startv_in    = startv_ff;
      first_in     = first_ff;
      cap_in       = cap_ff;
      z_in         = z_ff;
      mula_in      = mula_ff;
      mulb_in      = mulb_ff;
      prod_in      = prod_ff;
      dvs_in       = dvs_ff;
      unc_in       = unc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      div_start    = 1'b0;
      sq_start     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in = req_data.op;
               dt_in = req_data.time_step;
               v_in  = req_data.voltage_sample;
               case (req_data.op)
                  brke_pkg::OP_TICK: begin
                     est_in = (est_ff > {5'd0, req_data.time_step}) ?
                              est_ff - {5'd0, req_data.time_step} : 29'd0;
                     state_in = S_CAP;
                  end
                  brke_pkg::OP_MEASURE: state_in = S_CAP;
                  brke_pkg::OP_RESTART: begin
                     est_in    = dflt_ff;
                     cov_in    = COV_ONE;
                     el_in     = '0;
                     startv_in = '0;
                     first_in  = 1'b1;
                     state_in  = S_SQS;
                  end
                  default: state_in = S_SQS;
               endcase
            end
         end
         S_CAP: begin
            if (op_ff == brke_pkg::OP_TICK) begin
               cov_in   = cov_sum[32] ? 32'hFFFF_FFFF : cov_sum[31:0];
               el_in    = el_sum[40] ? brke_pkg::ELAPSED_MAX : el_sum[39:0];
               state_in = S_SQS;
            end else if (el_eff == '0 || sv_eff <= empty_ff || v_ff <= empty_ff ||
                         sv_eff <= v_ff) begin
               cap_in   = dflt_ff;
               state_in = S_Z;
            end else if (full_ff <= empty_ff) begin
               cap_in   = brke_pkg::CAP_MIN_MS;
               state_in = S_Z;
            end else begin
               mula_in  = el_eff;
               mulb_in  = {16'd0, dfe};
               dvs_in   = {17'd0, sv_eff - v_ff};
               ret_in   = S_CAPQ;
               state_in = S_MUL;
            end
         end
         S_CAPQ: begin
            if (quotient < {35'd0, brke_pkg::CAP_MIN_MS}) begin
               cap_in = brke_pkg::CAP_MIN_MS;
            end else if (quotient > {35'd0, brke_pkg::CAP_MAX_MS}) begin
               cap_in = brke_pkg::CAP_MAX_MS;
            end else begin
               cap_in = quotient[28:0];
            end
            state_in = S_Z;
         end
         S_Z: begin
            if (v_ff <= empty_ff) begin
               z_in     = '0;
               state_in = S_K;
            end else if (v_ff >= full_ff) begin
               z_in     = cap_ff;
               state_in = S_K;
            end else begin
               mula_in  = {11'd0, cap_ff};
               mulb_in  = {16'd0, v_ff - empty_ff};
               dvs_in   = {17'd0, dfe};
               ret_in   = S_ZQ;
               state_in = S_MUL;
            end
         end
         S_ZQ: begin
            z_in     = quotient[28:0];
            state_in = S_K;
         end
         S_K: begin
            if (first_ff) begin
               startv_in = v_ff;
               el_in     = '0;
               est_in    = z_ff;
               first_in  = 1'b0;
               state_in  = S_SQS;
            end else if (denom == '0) begin
               state_in = S_CLAMP;
            end else begin
               mula_in  = {8'd0, cov_ff};
               mulb_in  = {3'd0, mag};
               dvs_in   = denom;
               ret_in   = S_KQ;
               state_in = S_MUL;
            end
         end
         S_KQ: begin
            est_in   = (z_ff >= est_ff) ? est_ff + quotient[28:0] : est_ff - quotient[28:0];
            mula_in  = {8'd0, cov_ff};
            mulb_in  = {16'd0, r_ff};
            ret_in   = S_PQ;
            state_in = S_MUL;
         end
         S_PQ: begin
            cov_in   = quotient[31:0];
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            if (est_ff > cap_ff) begin
               est_in = cap_ff;
            end
            state_in = S_SQS;
         end
         S_MUL: begin
            prod_in  = 64'(mula_ff * mulb_ff);
            state_in = S_DIVS;
         end
         S_DIVS: begin
            div_start = 1'b1;
            state_in  = S_DIVW;
         end
         S_DIVW: begin
            if (div_status.done) begin
               state_in = ret_ff;
            end
         end
         S_SQS: begin
            sq_start = 1'b1;
            state_in = S_SQW;
         end
         S_SQW: begin
            if (sq_status.done) begin
               unc_in       = (root > 24'd65535) ? 16'hFFFF : root[15:0];
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      ret_ff  <= ret_in;
      op_ff   <= op_in;
      dt_ff   <= dt_in;
      v_ff    <= v_in;
      cap_ff  <= cap_in;
      z_ff    <= z_in;
      mula_ff <= mula_in;
      mulb_ff <= mulb_in;
      prod_ff <= prod_in;
      dvs_ff  <= dvs_in;
      unc_ff  <= unc_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         est_ff       <= 29'd3600000;
         cov_ff       <= COV_ONE;
         el_ff        <= '0;
         startv_ff    <= '0;
         first_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         est_ff       <= est_in;
         cov_ff       <= cov_in;
         el_ff        <= el_in;
         startv_ff    <= startv_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   brke_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (dvs_ff),
      .quotient (quotient),
      .status   (div_status)
   );

   brke_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_start),
      .operand (sq_operand),
      .root    (root),
      .status  (sq_status)
   );

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_data.remaining_time = est_ff;
   assign rsp_data.variance       = cov_ff;
   assign rsp_data.uncertainty    = unc_ff;

endmodule

>>> rtl/brke_checker.sv
// ----------------------------------------------------------------------------
// brke_checker
// Port-level checks of the estimator's handshakes.
// ----------------------------------------------------------------------------
module brke_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input brke_pkg::rsp_type rsp_data
);

   // A result beat that is held back stays up with the same payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat dropped or changed while stalled");

   // No new request is taken while a result beat waits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while a result beat waits");

   // An accepted request keeps the input closed and has no result yet.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall && !rsp_valid)
      else $error("input reopened or result shown too early");

endmodule

bind battery_runtime_kalman_estimator brke_checker u_brke_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives request beats into the battery runtime estimator with random gaps and
// stalls, predicts every response with an internal filter model and checks
// each response beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

   class runtime_scoreboard;
      logic [15:0] full_v, empty_v, q_noise, r_noise;
      logic [28:0] dflt_rt;
      logic [31:0] est;
      logic [31:0] cov;
      logic [39:0] elapsed;
      logic [15:0] start_v;
      bit first_pending;
      brke_pkg::rsp_type pending[$];
      int errors;

      function void set_defaults();
         full_v = 16'd12700; empty_v = 16'd10500; dflt_rt = 29'd3600000;
         q_noise = 16'd66; r_noise = 16'd3277; errors = 0;
         clear_filter();
      endfunction

      function void clear_filter();
         est = 32'(dflt_rt); cov = 32'h10000; elapsed = '0; start_v = '0;
         first_pending = 1;
      endfunction

      function void write_reg(logic [2:0] idx, logic [28:0] val);
         case (idx)
            brke_pkg::CSR_FULL_VOLTAGE: full_v = val[15:0];
            brke_pkg::CSR_EMPTY_VOLTAGE: empty_v = val[15:0];
            brke_pkg::CSR_DEFAULT_RUNTIME: dflt_rt = val;
            brke_pkg::CSR_PROCESS_NOISE: q_noise = val[15:0];
            brke_pkg::CSR_MEASUREMENT_NOISE: r_noise = val[15:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] cap_for(logic [15:0] v, logic [39:0] el);
         logic [63:0] c;
         if (el == '0 || start_v <= empty_v || v <= empty_v || start_v <= v) begin
            return 32'(dflt_rt);
         end
         if (full_v <= empty_v) return 32'd100;
         c = 64'(el) * 64'(full_v - empty_v) / 64'(start_v - v);
         if (c < 64'd100) c = 64'd100;
         if (c > 64'd360000000) c = 64'd360000000;
         return c[31:0];
      endfunction

      function logic [31:0] runtime_for(logic [15:0] v, logic [39:0] el);
         logic [63:0] c;
         if (v <= empty_v) return 32'd0;
         c = 64'(cap_for(v, el));
         if (v >= full_v) return c[31:0];
         c = c * 64'(v - empty_v) / 64'(full_v - empty_v);
         return c[31:0];
      endfunction

      function logic [15:0] root_q88(logic [31:0] p);
         logic [63:0] n, root, b;
         n = 64'(p); root = '0; b = 64'h1 << 62;
         while (b > n) b = b >> 2;
         while (b != '0) begin
            if (n >= root + b) begin
               n = n - (root + b);
               root = (root >> 1) + b;
            end else begin
               root = root >> 1;
            end
            b = b >> 2;
         end
         return (root > 64'd65535) ? 16'hFFFF : root[15:0];
      endfunction

      function void note_request(brke_pkg::req_type r);
         logic [63:0] s, den, mag, corr;
         logic [31:0] z, c;
         brke_pkg::rsp_type o;
         case (r.op)
            brke_pkg::OP_TICK: begin
               est = (est > 32'(r.time_step)) ? est - 32'(r.time_step) : 32'd0;
               s = 64'(cov) + 64'(q_noise);
               cov = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
               s = 64'(elapsed) + 64'(r.time_step);
               elapsed = (s > 64'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : s[39:0];
            end
            brke_pkg::OP_MEASURE: begin
               if (first_pending) begin
                  start_v = r.voltage_sample;
                  elapsed = '0;
                  est = runtime_for(r.voltage_sample, 40'd1);
                  first_pending = 0;
               end else begin
                  z = runtime_for(r.voltage_sample, elapsed);
                  den = 64'(cov) + 64'(r_noise);
                  if (den != '0) begin
                     mag = (z >= est) ? 64'(z - est) : 64'(est - z);
                     corr = 64'(cov) * mag / den;
                     if (z >= est) est = est + corr[31:0];
                     else est = est - corr[31:0];
                     s = 64'(cov) * 64'(r_noise) / den;
                     cov = s[31:0];
                  end
                  c = cap_for(r.voltage_sample, elapsed);
                  if (est > c) est = c;
               end
            end
            brke_pkg::OP_RESTART: clear_filter();
            default: ;
         endcase
         o.remaining_time = est[28:0];
         o.variance = cov;
         o.uncertainty = root_q88(cov);
         pending.push_back(o);
      endfunction

      function void check_response(brke_pkg::rsp_type a);
         brke_pkg::rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected response beat %h", a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.remaining_time !== e.remaining_time) begin
            $error("remaining_time expected %0d actual %0d", e.remaining_time, a.remaining_time);
            errors++;
         end
         if (a.variance !== e.variance) begin
            $error("variance expected %0d actual %0d", e.variance, a.variance);
            errors++;
         end
         if (a.uncertainty !== e.uncertainty) begin
            $error("uncertainty expected %0d actual %0d", e.uncertainty, a.uncertainty);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall, rsp_valid, rsp_stall = 0;
   brke_pkg::req_type req_data = '0;
   brke_pkg::rsp_type rsp_data;
   logic csr_write = 0;
   logic [2:0] csr_index = '0;
   logic [28:0] csr_wdata = '0;
   bit quiet = 0;
   runtime_scoreboard sb;

   battery_runtime_kalman_estimator uut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_data);
   end

   always @(posedge clock) begin
      int n;
      if (reset || quiet) begin
         rsp_stall <= 0;
      end else if ($urandom_range(0, 5) == 0) begin
         n = $urandom_range(1, 4);
         rsp_stall <= 1;
         repeat (n) @(posedge clock);
         rsp_stall <= 0;
      end else begin
         rsp_stall <= 0;
      end
   end

   task automatic send(logic [1:0] op, logic [23:0] dt, logic [15:0] v);
      brke_pkg::req_type r;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      r.op = op; r.time_step = dt; r.voltage_sample = v;
      req_data <= r;
      req_valid <= 1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(r);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [28:0] val);
      csr_write <= 1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
      csr_write <= 0;
      @(posedge clock);
   endtask

   task automatic random_phase(int count);
      logic [15:0] v;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 19))
            0: send(brke_pkg::OP_RESTART, 24'($urandom), 16'($urandom));
            1: send(brke_pkg::OP_SPARE, 24'($urandom), 16'($urandom));
            2, 3: send(brke_pkg::OP_TICK, 24'($urandom), 16'($urandom));
            4, 5, 6, 7, 8, 9: begin
               send(brke_pkg::OP_TICK, 24'($urandom_range(0, 60000)), 16'($urandom));
            end
            10: send(brke_pkg::OP_MEASURE, 24'($urandom), 16'($urandom));
            default: begin
               v = 16'(32'(sb.empty_v) + $urandom_range(0, 2600) - 32'd200);
               send(brke_pkg::OP_MEASURE, 24'($urandom), v);
            end
         endcase
      end
   endtask

   initial begin
      sb = new();
      sb.set_defaults();
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send(brke_pkg::OP_TICK, 24'hFFFFFF, 16'hFFFF);
      send(brke_pkg::OP_MEASURE, 24'd0, 16'd12000);
      send(brke_pkg::OP_TICK, 24'd0, 16'd0);
      send(brke_pkg::OP_TICK, 24'd60000, 16'd0);
      send(brke_pkg::OP_MEASURE, 24'd0, 16'd11800);
      send(brke_pkg::OP_MEASURE, 24'd0, 16'd12800);
      send(brke_pkg::OP_MEASURE, 24'd0, 16'd10000);
      send(brke_pkg::OP_SPARE, 24'hFFFFFF, 16'hFFFF);
      send(brke_pkg::OP_RESTART, 24'd0, 16'd0);
      send(brke_pkg::OP_MEASURE, 24'hFFFFFF, 16'h0000);
      send(brke_pkg::OP_MEASURE, 24'd0, 16'hFFFF);
      send(brke_pkg::OP_RESTART, 24'd0, 16'd0);
      send(brke_pkg::OP_MEASURE, 24'd0, 16'hFFFF);
      send(brke_pkg::OP_TICK, 24'hFFFFFF, 16'd0);
      send(brke_pkg::OP_MEASURE, 24'd0, 16'd12000);
      drain();
      random_phase(300);
      drain();
      write_csr(brke_pkg::CSR_FULL_VOLTAGE, 29'hFFFF);
      write_csr(brke_pkg::CSR_EMPTY_VOLTAGE, 29'd0);
      write_csr(brke_pkg::CSR_DEFAULT_RUNTIME, 29'd360000000);
      write_csr(brke_pkg::CSR_PROCESS_NOISE, 29'hFFFF);
      write_csr(brke_pkg::CSR_MEASUREMENT_NOISE, 29'd1);
      send(brke_pkg::OP_RESTART, 24'd0, 16'd0);
      random_phase(250);
      for (int i = 0; i < 20; i++) send(brke_pkg::OP_TICK, 24'hFFFFFF, 16'd0);
      drain();
      write_csr(brke_pkg::CSR_FULL_VOLTAGE, 29'd10000);
      write_csr(brke_pkg::CSR_EMPTY_VOLTAGE, 29'd12000);
      write_csr(brke_pkg::CSR_DEFAULT_RUNTIME, 29'd100);
      write_csr(brke_pkg::CSR_PROCESS_NOISE, 29'd0);
      write_csr(brke_pkg::CSR_MEASUREMENT_NOISE, 29'hFFFF);
      send(brke_pkg::OP_RESTART, 24'd0, 16'd0);
      random_phase(200);
      drain();
      write_csr(brke_pkg::CSR_FULL_VOLTAGE, 29'd12600);
      write_csr(brke_pkg::CSR_EMPTY_VOLTAGE, 29'd11000);
      write_csr(brke_pkg::CSR_DEFAULT_RUNTIME, 29'($urandom_range(100, 360000000)));
      write_csr(brke_pkg::CSR_PROCESS_NOISE, 29'($urandom));
      write_csr(brke_pkg::CSR_MEASUREMENT_NOISE, 29'($urandom_range(1, 65535)));
      send(brke_pkg::OP_RESTART, 24'd0, 16'd0);
      random_phase(300);
      drain();
      write_csr(brke_pkg::CSR_FULL_VOLTAGE, 29'd12700);
      write_csr(brke_pkg::CSR_EMPTY_VOLTAGE, 29'd10500);
      write_csr(brke_pkg::CSR_DEFAULT_RUNTIME, 29'd3600000);
      write_csr(brke_pkg::CSR_PROCESS_NOISE, 29'd66);
      write_csr(brke_pkg::CSR_MEASUREMENT_NOISE, 29'd3277);
      random_phase(150);
      quiet = 1;
      random_phase(120);
      drain();
      if (sb.errors == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("tb_top: done, errors");
      $finish;
   end
endmodule
